@@ hw/rtl/hfcd_pkg.sv @@
`default_nettype none
package hfcd_pkg;

	localparam int CH_W    = 8;
	localparam int EV_W    = 3;
	localparam int POS_W   = 17;
	localparam int CFG_IDX_W = 1;

	localparam logic [CH_W-1:0] FRAME_START_RST = 8'h24;
	localparam logic [CH_W-1:0] LINE_END_RST    = 8'h0A;
	localparam logic [CH_W-1:0] CH_ESC          = 8'h1B;
	localparam logic [CH_W-1:0] CH_BS           = 8'h08;
	localparam logic [CH_W-1:0] CH_DEL          = 8'h7F;
	localparam logic [CH_W-1:0] CH_PRINT_LO     = 8'h20;
	localparam logic [CH_W-1:0] CH_PRINT_HI     = 8'h7E;
	localparam logic [15:0]     UP_ARROW_TAIL   = 16'h5B41;
	localparam logic [POS_W-1:0] LEN_DIGITS     = 17'd4;
	localparam logic [POS_W-1:0] LOW_DONE_LEFT  = 17'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_START = 1'b0,
		REG_LINE_END    = 1'b1
	} cfg_reg_t;

	typedef enum logic [EV_W-1:0] {
		EV_LEN_BYTE   = 3'd0,
		EV_PAY_BYTE   = 3'd1,
		EV_TEXT_STORE = 3'd2,
		EV_TEXT_ERASE = 3'd3,
		EV_LINE_DONE  = 3'd4,
		EV_UP_ARROW   = 3'd5
	} event_t;

	typedef struct packed {
		logic             valid;
		event_t           ev;
		logic [CH_W-1:0]  data;
		logic [POS_W-1:0] pos;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [CH_W-1:0] frame_start;
		logic [CH_W-1:0] line_end;
	} cfg_t;

	function automatic logic [3:0] hex_nibble(input logic [CH_W-1:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) n = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			n = 4'(c[3:0] + 4'd9);
		return n;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hfcd_core.sv @@
`default_nettype none
module hfcd_core #(
	parameter int LINE_CAPACITY = 512
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     fire,
	input  wire logic [hfcd_pkg::CH_W-1:0] ch,
	input  wire hfcd_pkg::cfg_t           cfg,
	output hfcd_pkg::result_t             res
);

	localparam logic [hfcd_pkg::POS_W-1:0] FULL_POS = hfcd_pkg::POS_W'(LINE_CAPACITY - 1);

	logic                        in_bin_q, in_bin_d;
	logic                        len_known_q, len_known_d;
	logic [hfcd_pkg::POS_W-1:0]  digits_q, digits_d;
	logic [7:0]                  acc_q, acc_d;
	logic [7:0]                  len_lo_q, len_lo_d;
	logic [hfcd_pkg::POS_W-1:0]  wpos_q, wpos_d;
	logic [1:0]                  esc_rem_q, esc_rem_d;
	logic [15:0]                 esc_chars_q, esc_chars_d;

	logic [7:0]                  acc_n;
	logic [hfcd_pkg::POS_W-1:0]  digits_n;
	logic [15:0]                 len;
	logic [hfcd_pkg::POS_W-1:0]  wpos_t;
	logic                        stored, erased, done;

	always_comb begin
		in_bin_d    = in_bin_q;
		len_known_d = len_known_q;
		digits_d    = digits_q;
		acc_d       = acc_q;
		len_lo_d    = len_lo_q;
		wpos_d      = wpos_q;
		esc_rem_d   = esc_rem_q;
		esc_chars_d = esc_chars_q;
		res         = '0;
		acc_n       = {acc_q[3:0], hfcd_pkg::hex_nibble(ch)};
		digits_n    = digits_q - 1'b1;
		len         = {acc_n, len_lo_q};
		wpos_t      = wpos_q;
		stored      = 1'b0;
		erased      = 1'b0;
		done        = 1'b0;
		if (!in_bin_q && wpos_q == '0 && esc_rem_q == 2'd0 && ch == cfg.frame_start) begin
			in_bin_d    = 1'b1;
			len_known_d = 1'b0;
			digits_d    = hfcd_pkg::LEN_DIGITS;
			acc_d       = '0;
			len_lo_d    = '0;
		end else if (in_bin_q) begin
			digits_d = digits_n;
			if (digits_n[0]) begin
				acc_d = acc_n;
			end else begin
				acc_d     = '0;
				wpos_d    = wpos_q + 1'b1;
				res.valid = 1'b1;
				res.data  = acc_n;
				res.pos   = wpos_q;
				if (!len_known_q) begin
					res.ev = hfcd_pkg::EV_LEN_BYTE;
					if (digits_n == hfcd_pkg::LOW_DONE_LEFT) begin
						len_lo_d = acc_n;
					end else begin
						len_known_d = 1'b1;
						digits_d    = {len, 1'b0};
						if (len == '0) begin
							in_bin_d    = 1'b0;
							len_known_d = 1'b0;
							digits_d    = '0;
							wpos_d      = '0;
							res.last    = 1'b1;
						end
					end
				end else begin
					res.ev = hfcd_pkg::EV_PAY_BYTE;
					if (digits_n == '0) begin
						in_bin_d    = 1'b0;
						len_known_d = 1'b0;
						wpos_d      = '0;
						res.last    = 1'b1;
					end
				end
			end
		end else if (esc_rem_q != 2'd0) begin
			esc_chars_d = {esc_chars_q[7:0], ch};
			esc_rem_d   = esc_rem_q - 1'b1;
			if (esc_rem_d == 2'd0 && esc_chars_d == hfcd_pkg::UP_ARROW_TAIL) begin
				res.valid = 1'b1;
				res.ev    = hfcd_pkg::EV_UP_ARROW;
				res.pos   = wpos_q;
			end
		end else begin
			if (ch == hfcd_pkg::CH_ESC) begin
				esc_rem_d   = 2'd2;
				esc_chars_d = '0;
			end else if (ch == hfcd_pkg::CH_BS || ch == hfcd_pkg::CH_DEL) begin
				if (wpos_q != '0) begin
					wpos_t = wpos_q - 1'b1;
					erased = 1'b1;
				end
			end else if (ch >= hfcd_pkg::CH_PRINT_LO && ch <= hfcd_pkg::CH_PRINT_HI) begin
				wpos_t = wpos_q + 1'b1;
				stored = 1'b1;
			end
			done   = (ch == cfg.line_end) || (wpos_t >= FULL_POS);
			wpos_d = done ? '0 : wpos_t;
			if (done) begin
				res.valid = 1'b1;
				res.ev    = hfcd_pkg::EV_LINE_DONE;
				res.data  = stored ? ch : '0;
				res.pos   = wpos_t;
				res.last  = 1'b1;
			end else if (stored) begin
				res.valid = 1'b1;
				res.ev    = hfcd_pkg::EV_TEXT_STORE;
				res.data  = ch;
				res.pos   = wpos_q;
			end else if (erased) begin
				res.valid = 1'b1;
				res.ev    = hfcd_pkg::EV_TEXT_ERASE;
				res.pos   = wpos_t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bin_q    <= 1'b0;
			len_known_q <= 1'b0;
			digits_q    <= '0;
			acc_q       <= '0;
			len_lo_q    <= '0;
			wpos_q      <= '0;
			esc_rem_q   <= '0;
			esc_chars_q <= '0;
		end else if (fire) begin
			in_bin_q    <= in_bin_d;
			len_known_q <= len_known_d;
			digits_q    <= digits_d;
			acc_q       <= acc_d;
			len_lo_q    <= len_lo_d;
			wpos_q      <= wpos_d;
			esc_rem_q   <= esc_rem_d;
			esc_chars_q <= esc_chars_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/hex_framed_command_deframer.sv @@
// channel | handshake             | payload
// char    | char_valid/char_stall | ch
// result  | res_valid/res_stall   | event_res, data_byte, position, last_of_command
// config  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// one character per cycle sustained while no result is held; a result is formed from its character
// through the input register, then decode against the line state into the result register
// arst_n clears mode, length, line and escape state and restores the config defaults
// a held result stalls the input register, and char_stall rises once that register is full
`default_nettype none
module hex_framed_command_deframer #(
	parameter int LINE_CAPACITY = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [hfcd_pkg::CH_W-1:0]     ch,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [hfcd_pkg::EV_W-1:0]          event_res,
	output logic [hfcd_pkg::CH_W-1:0]          data_byte,
	output logic [hfcd_pkg::POS_W-1:0]         position,
	output logic                               last_of_command,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hfcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hfcd_pkg::CH_W-1:0]     cfg_data
);

	hfcd_pkg::cfg_t              cfg_q;
	logic                        valid_s1;
	logic [hfcd_pkg::CH_W-1:0]   ch_s1;
	logic                        out_free;
	logic                        fire;
	hfcd_pkg::result_t           res;
	hfcd_pkg::result_t           res_q;

	assign cfg_ready  = 1'b1;
	assign out_free   = !res_q.valid || !res_stall;
	assign fire       = valid_s1 && out_free;
	assign char_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_start <= hfcd_pkg::FRAME_START_RST;
			cfg_q.line_end    <= hfcd_pkg::LINE_END_RST;
		end else if (cfg_valid) begin
			unique case (hfcd_pkg::cfg_reg_t'(cfg_index))
				hfcd_pkg::REG_FRAME_START: cfg_q.frame_start <= cfg_data;
				hfcd_pkg::REG_LINE_END:    cfg_q.line_end    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			ch_s1 <= ch;
		end
	end

	hfcd_core #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.ch    (ch_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (out_free) begin
			res_q.valid <= fire && res.valid;
			if (fire) begin
				res_q.ev   <= res.ev;
				res_q.data <= res.data;
				res_q.pos  <= res.pos;
				res_q.last <= res.last;
			end
		end
	end

	assign res_valid       = res_q.valid;
	assign event_res       = res_q.ev;
	assign data_byte       = res_q.data;
	assign position        = res_q.pos;
	assign last_of_command = res_q.last;

endmodule
`default_nettype wire
